[hdl/bpc_pkg.sv]
package bpc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;
  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegAc1Ac2 = 3'd0;
  localparam logic [RegIdxW-1:0] RegAc3Ac4 = 3'd1;
  localparam logic [RegIdxW-1:0] RegAc5Ac6 = 3'd2;
  localparam logic [RegIdxW-1:0] RegB1B2 = 3'd3;
  localparam logic [RegIdxW-1:0] RegMcMd = 3'd4;
  localparam logic [RegIdxW-1:0] RegOss = 3'd5;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusTempDivZero = 2'd1;
  localparam logic [1:0] StatusPresDivZero = 2'd2;

endpackage

[hdl/bpc_div.sv]
module bpc_div
  import bpc_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [DataW-1:0] quo_o,
  output logic [SideW-1:0] side_o
);

  // One restoring step per stage; the quotient bits shift in behind the dividend.
  logic             v_q    [DataW];
  logic [DataW-1:0] rem_q  [DataW];
  logic [DataW-1:0] num_q  [DataW];
  logic [DataW-1:0] den_q  [DataW];
  logic [SideW-1:0] side_q [DataW];

  logic             src_v    [DataW];
  logic [DataW-1:0] src_rem  [DataW];
  logic [DataW-1:0] src_num  [DataW];
  logic [DataW-1:0] src_den  [DataW];
  logic [SideW-1:0] src_side [DataW];
  logic [DataW-1:0] rem_d    [DataW];
  logic [DataW-1:0] num_d    [DataW];
  logic [DataW:0]   trial    [DataW];

  always_comb begin
    src_v[0]    = valid_i;
    src_rem[0]  = '0;
    src_num[0]  = num_i;
    src_den[0]  = den_i;
    src_side[0] = side_i;
    for (int k = 1; k < DataW; k++) begin
      src_v[k]    = v_q[k-1];
      src_rem[k]  = rem_q[k-1];
      src_num[k]  = num_q[k-1];
      src_den[k]  = den_q[k-1];
      src_side[k] = side_q[k-1];
    end
    for (int k = 0; k < DataW; k++) begin
      trial[k] = {src_rem[k], src_num[k][DataW-1]};
      if (trial[k] >= {1'b0, src_den[k]}) begin
        rem_d[k] = DataW'(trial[k] - {1'b0, src_den[k]});
        num_d[k] = {src_num[k][DataW-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[k][DataW-1:0];
        num_d[k] = {src_num[k][DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DataW; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < DataW; k++) v_q[k] <= src_v[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DataW; k++) begin
        rem_q[k]  <= rem_d[k];
        num_q[k]  <= num_d[k];
        den_q[k]  <= src_den[k];
        side_q[k] <= src_side[k];
      end
    end
  end

  assign valid_o = v_q[DataW-1];
  assign quo_o   = num_q[DataW-1];
  assign side_o  = side_q[DataW-1];

endmodule

[hdl/barometric_pressure_compensation_core.sv]
// Channel   Signals                                                      Direction
// input     in_valid_i, in_ready_o, raw_temperature_i, raw_pressure_i    in
// output    out_valid_o, out_ready_i, temperature_tenths_o, pressure_pa_o,
//           status_o                                                     out
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready         in/out
//
// One item enters per cycle while the output is free to advance.
// The pipeline is made of the two 32-stage restoring dividers plus 14 arithmetic stages.
// Reset clears the valid bits and the calibration registers.
// A stalled output holds the whole pipeline, so no item is lost or repeated.
module barometric_pressure_compensation_core
  import bpc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [15:0]             raw_temperature_i,
  input  logic [18:0]             raw_pressure_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] temperature_tenths_o,
  output logic signed [DataW-1:0] pressure_pa_o,
  output logic [1:0]              status_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  logic [DataW-1:0] ac1ac2_q, ac3ac4_q, ac5ac6_q, b1b2_q, mcmd_q;
  logic [1:0]       oss_q;
  logic [RegIdxW-1:0] widx;

  assign widx   = paddr[AddrW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1ac2_q <= '0;
      ac3ac4_q <= '0;
      ac5ac6_q <= '0;
      b1b2_q   <= '0;
      mcmd_q   <= '0;
      oss_q    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        RegAc1Ac2: ac1ac2_q <= pwdata;
        RegAc3Ac4: ac3ac4_q <= pwdata;
        RegAc5Ac6: ac5ac6_q <= pwdata;
        RegB1B2:   b1b2_q   <= pwdata;
        RegMcMd:   mcmd_q   <= pwdata;
        RegOss:    oss_q    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      RegAc1Ac2: prdata = ac1ac2_q;
      RegAc3Ac4: prdata = ac3ac4_q;
      RegAc5Ac6: prdata = ac5ac6_q;
      RegB1B2:   prdata = b1b2_q;
      RegMcMd:   prdata = mcmd_q;
      RegOss:    prdata = {{(DataW-2){1'b0}}, oss_q};
      default:   prdata = '0;
    endcase
  end

  // Calibration fields, widened to the 32-bit working width.
  logic [DataW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ac1ac2_q[31]}}, ac1ac2_q[31:16]};
  assign ac2 = {{16{ac1ac2_q[15]}}, ac1ac2_q[15:0]};
  assign ac3 = {{16{ac3ac4_q[31]}}, ac3ac4_q[31:16]};
  assign ac4 = {16'd0, ac3ac4_q[15:0]};
  assign ac5 = {16'd0, ac5ac6_q[31:16]};
  assign ac6 = {16'd0, ac5ac6_q[15:0]};
  assign b1  = {{16{b1b2_q[31]}}, b1b2_q[31:16]};
  assign b2  = {{16{b1b2_q[15]}}, b1b2_q[15:0]};
  assign mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
  assign md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: temperature product.
  logic v1_q;
  logic [DataW-1:0] prod1_q;
  logic [18:0] up1_q;

  // Stage 2: divider set-up for X2.
  logic v2_q;
  logic [DataW-1:0] x1_2_q, ma_2_q, mb_2_q;
  logic [18:0] up2_q;
  logic neg2_q, tz2_q;
  logic [DataW-1:0] x1_2_d, den_2_d, mcs_2_d;

  localparam int unsigned Side1W = DataW + 19 + 2;
  logic d1_v;
  logic [DataW-1:0] d1_q;
  logic [Side1W-1:0] d1_side;

  // Stages 3 to 10.
  logic v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic [DataW-1:0] b5_3_q, temp3_q, temp4_q, temp5_q, temp6_q, temp7_q, temp8_q, temp9_q;
  logic [DataW-1:0] temp10_q;
  logic [18:0] up3_q, up4_q, up5_q, up6_q, up7_q;
  logic tz3_q, tz4_q, tz5_q, tz6_q, tz7_q, tz8_q, tz9_q, tz10_q;
  logic [DataW-1:0] b6_4_q, b6sq_4_q, ac2b6_4_q, ac3b6_4_q;
  logic [DataW-1:0] sq5_q, x2a5_q, x1c5_q, x2a6_q, x1c6_q, b2sq6_q, b1sq6_q;
  logic [DataW-1:0] b3_7_q, x3b7_q, b4_8_q, diff8_q, b4_9_q, b7_9_q;
  logic [DataW-1:0] num10_q, den10_q;
  logic big10_q, b4z10_q;

  logic [DataW-1:0] x2_3_d, b5_3_d, b5r_3_d, b6_4_d;
  logic [DataW-1:0] x3_7_d, t1_7_d, t1r_7_d, x3s_7_d;

  always_comb begin
    x1_2_d  = DataW'($signed(prod1_q) >>> 15);
    den_2_d = x1_2_d + md;
    mcs_2_d = mc << 11;

    x2_3_d  = d1_side[1] ? (DataW'(0) - d1_q) : d1_q;
    b5_3_d  = d1_side[Side1W-1 -: DataW] + x2_3_d;
    b5r_3_d = b5_3_d + DataW'(8);

    b6_4_d  = b5_3_q - DataW'(4000);

    x3_7_d  = DataW'($signed(b2sq6_q) >>> 11) + x2a6_q;
    t1_7_d  = ((ac1 << 2) + x3_7_d) << oss_q;
    t1_7_d  = t1_7_d + DataW'(2);
    // Signed division by four, truncating toward zero.
    t1r_7_d = t1_7_d + (t1_7_d[DataW-1] ? DataW'(3) : DataW'(0));
    x3s_7_d = DataW'($signed(b1sq6_q) >>> 16) + x1c6_q + DataW'(2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= d1_v; v4_q <= v3_q; v5_q <= v4_q;
      v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q; v9_q <= v8_q; v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod1_q <= ({16'd0, raw_temperature_i} - ac6) * ac5;
      up1_q   <= raw_pressure_i;

      x1_2_q <= x1_2_d;
      ma_2_q <= mcs_2_d[DataW-1] ? (DataW'(0) - mcs_2_d) : mcs_2_d;
      mb_2_q <= den_2_d[DataW-1] ? (DataW'(0) - den_2_d) : den_2_d;
      neg2_q <= mcs_2_d[DataW-1] ^ den_2_d[DataW-1];
      tz2_q  <= (den_2_d == '0);
      up2_q  <= up1_q;

      b5_3_q  <= b5_3_d;
      temp3_q <= DataW'($signed(b5r_3_d) >>> 4);
      up3_q   <= d1_side[Side1W-DataW-1 -: 19];
      tz3_q   <= d1_side[0];

      b6_4_q    <= b6_4_d;
      b6sq_4_q  <= b6_4_d * b6_4_d;
      ac2b6_4_q <= ac2 * b6_4_d;
      ac3b6_4_q <= ac3 * b6_4_d;
      temp4_q <= temp3_q; up4_q <= up3_q; tz4_q <= tz3_q;

      sq5_q  <= DataW'($signed(b6sq_4_q) >>> 12);
      x2a5_q <= DataW'($signed(ac2b6_4_q) >>> 11);
      x1c5_q <= DataW'($signed(ac3b6_4_q) >>> 13);
      temp5_q <= temp4_q; up5_q <= up4_q; tz5_q <= tz4_q;

      b2sq6_q <= b2 * sq5_q;
      b1sq6_q <= b1 * sq5_q;
      x2a6_q <= x2a5_q; x1c6_q <= x1c5_q;
      temp6_q <= temp5_q; up6_q <= up5_q; tz6_q <= tz5_q;

      b3_7_q <= DataW'($signed(t1r_7_d) >>> 2);
      x3b7_q <= DataW'($signed(x3s_7_d) >>> 2);
      temp7_q <= temp6_q; up7_q <= up6_q; tz7_q <= tz6_q;

      b4_8_q  <= (ac4 * (x3b7_q + DataW'(32768))) >> 15;
      diff8_q <= {13'd0, up7_q} - b3_7_q;
      temp8_q <= temp7_q; tz8_q <= tz7_q;

      b7_9_q <= diff8_q * (DataW'(50000) >> oss_q);
      b4_9_q <= b4_8_q;
      temp9_q <= temp8_q; tz9_q <= tz8_q;

      big10_q  <= b7_9_q[DataW-1];
      num10_q  <= b7_9_q[DataW-1] ? b7_9_q : (b7_9_q << 1);
      den10_q  <= b4_9_q;
      b4z10_q  <= (b4_9_q == '0);
      temp10_q <= temp9_q; tz10_q <= tz9_q;
    end
  end

  bpc_div #(.SideW(Side1W)) u_div_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .num_i   (ma_2_q),
    .den_i   (mb_2_q),
    .side_i  ({x1_2_q, up2_q, neg2_q, tz2_q}),
    .valid_o (d1_v),
    .quo_o   (d1_q),
    .side_o  (d1_side)
  );

  localparam int unsigned Side2W = DataW + 3;
  logic d2_v;
  logic [DataW-1:0] d2_q;
  logic [Side2W-1:0] d2_side;

  bpc_div #(.SideW(Side2W)) u_div_pres (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v10_q),
    .num_i   (num10_q),
    .den_i   (den10_q),
    .side_i  ({temp10_q, big10_q, b4z10_q, tz10_q}),
    .valid_o (d2_v),
    .quo_o   (d2_q),
    .side_o  (d2_side)
  );

  // Stages 11 to 14: final pressure correction and the output register.
  logic v11_q, v12_q, v13_q, out_v_q;
  logic [DataW-1:0] p11_q, p12_q, p13_q, temp11_q, temp12_q, temp13_q;
  logic [DataW-1:0] x1sq12_q, m2_12_q, y13_q, x2f13_q;
  logic b4z11_q, tz11_q, b4z12_q, tz12_q, b4z13_q, tz13_q;
  logic [DataW-1:0] temp_out_q, pres_out_q;
  logic [1:0] status_q;
  logic [DataW-1:0] x1_12_d, corr_14_d, pf_14_d;

  always_comb begin
    x1_12_d   = DataW'($signed(p11_q) >>> 8);
    corr_14_d = DataW'($signed(y13_q) >>> 16) + x2f13_q + DataW'(3791);
    pf_14_d   = p13_q + DataW'($signed(corr_14_d) >>> 4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q <= 1'b0; v12_q <= 1'b0; v13_q <= 1'b0; out_v_q <= 1'b0;
    end else if (adv) begin
      v11_q <= d2_v; v12_q <= v11_q; v13_q <= v12_q; out_v_q <= v13_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p11_q    <= d2_side[2] ? (d2_q << 1) : d2_q;
      temp11_q <= d2_side[Side2W-1 -: DataW];
      b4z11_q  <= d2_side[1];
      tz11_q   <= d2_side[0];

      x1sq12_q <= x1_12_d * x1_12_d;
      m2_12_q  <= p11_q * (DataW'(0) - DataW'(7357));
      p12_q <= p11_q; temp12_q <= temp11_q; b4z12_q <= b4z11_q; tz12_q <= tz11_q;

      y13_q   <= x1sq12_q * DataW'(3038);
      x2f13_q <= DataW'($signed(m2_12_q) >>> 16);
      p13_q <= p12_q; temp13_q <= temp12_q; b4z13_q <= b4z12_q; tz13_q <= tz12_q;

      if (tz13_q) begin
        temp_out_q <= '0;
        pres_out_q <= '0;
        status_q   <= StatusTempDivZero;
      end else if (b4z13_q) begin
        temp_out_q <= temp13_q;
        pres_out_q <= '0;
        status_q   <= StatusPresDivZero;
      end else begin
        temp_out_q <= temp13_q;
        pres_out_q <= pf_14_d;
        status_q   <= StatusOk;
      end
    end
  end

  assign out_valid_o          = out_v_q;
  assign temperature_tenths_o = temp_out_q;
  assign pressure_pa_o        = pres_out_q;
  assign status_o             = status_q;

endmodule
